FILE: rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared constants, codes and types of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

  // Store geometry.
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int DATA_W = 32;

  // Capacity register.
  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Request actions.
  localparam logic [1:0] ACT_PUSH_HEAD = 2'd0;
  localparam logic [1:0] ACT_PUSH_TAIL = 2'd1;
  localparam logic [1:0] ACT_POP_HEAD  = 2'd2;
  localparam logic [1:0] ACT_POP_TAIL  = 2'd3;

  // Result status codes.
  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_POPPED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  // One access of the entry store.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } mem_cmd_t;

  // Result of a request as known in its accept cycle.
  typedef struct packed {
    logic              valid;
    logic [1:0]        status;
    logic              from_mem;
    logic [DATA_W-1:0] value;
  } resp_t;

  // Fold a sum below twice the depth back into the circular index range.
  function automatic logic [ADDR_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] d;
    d = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
    return d[ADDR_W-1:0];
  endfunction

endpackage

FILE: rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic              re,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Front pointer and fill count of the circular store; decides each request
// and issues the store access that goes with it.
// ----------------------------------------------------------------------------
module bdq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_fire,
  input  logic [1:0]                   action,
  input  logic [bdq_pkg::DATA_W-1:0]   push_value,
  input  logic [bdq_pkg::CAP_W-1:0]    capacity,
  output bdq_pkg::mem_cmd_t            mem_cmd,
  output bdq_pkg::resp_t               resp
);

  logic [bdq_pkg::ADDR_W-1:0] front_r, front_nxt;
  logic [bdq_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [bdq_pkg::LIM_W-1:0]  cap_ext;
  logic [bdq_pkg::LIM_W-1:0]  limit;
  logic [bdq_pkg::LIM_W-1:0]  count_ext;
  logic [bdq_pkg::SUM_W-1:0]  front_sum;
  logic [bdq_pkg::SUM_W-1:0]  count_sum;
  logic                       is_full;
  logic                       is_empty;

  // Effective limit saturates at the store depth.
  assign cap_ext   = bdq_pkg::LIM_W'(capacity);
  assign limit     = (cap_ext >= bdq_pkg::LIM_W'(bdq_pkg::DEPTH)) ?
                     bdq_pkg::LIM_W'(bdq_pkg::DEPTH) : cap_ext;
  assign count_ext = bdq_pkg::LIM_W'(count_r);
  assign is_full   = (count_ext >= limit);
  assign is_empty  = (count_r == '0);
  assign front_sum = bdq_pkg::SUM_W'(front_r);
  assign count_sum = bdq_pkg::SUM_W'(count_r);

  // Request decode: next pointer, next count, store access and status.
  always_comb begin
    front_nxt     = front_r;
    count_nxt     = count_r;
    mem_cmd       = '0;
    mem_cmd.wdata = push_value;
    resp          = '0;
    resp.valid    = req_fire;
    case (action)
      bdq_pkg::ACT_PUSH_HEAD, bdq_pkg::ACT_PUSH_TAIL: begin
        if (is_full) begin
          resp.status = bdq_pkg::ST_FULL;
        end else begin
          resp.status = bdq_pkg::ST_PUSHED;
          resp.value  = push_value;
          mem_cmd.we  = req_fire;
          count_nxt   = count_r + bdq_pkg::CNT_W'(1);
          if (action == bdq_pkg::ACT_PUSH_HEAD) begin
            front_nxt    = (front_r == '0) ? bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1)
                                           : front_r - bdq_pkg::ADDR_W'(1);
            mem_cmd.addr = front_nxt;
          end else begin
            mem_cmd.addr = bdq_pkg::wrap_idx(front_sum + count_sum);
          end
        end
      end
      bdq_pkg::ACT_POP_HEAD, bdq_pkg::ACT_POP_TAIL: begin
        if (is_empty) begin
          resp.status = bdq_pkg::ST_EMPTY;
        end else begin
          resp.status   = bdq_pkg::ST_POPPED;
          resp.from_mem = 1'b1;
          mem_cmd.re    = req_fire;
          count_nxt     = count_r - bdq_pkg::CNT_W'(1);
          if (action == bdq_pkg::ACT_POP_HEAD) begin
            mem_cmd.addr = front_r;
            front_nxt    = bdq_pkg::wrap_idx(front_sum + bdq_pkg::SUM_W'(1));
          end else begin
            mem_cmd.addr = bdq_pkg::wrap_idx(front_sum + count_sum -
                                             bdq_pkg::SUM_W'(1));
          end
        end
      end
      default: begin
        resp.status = bdq_pkg::ST_EMPTY;
      end
    endcase
  end

  // Pointer and count registers change only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      count_r <= '0;
    end else if (req_fire) begin
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  // The count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("deque count exceeds store depth");

  // The front pointer stays inside the store.
  a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bdq_pkg::CNT_W'(front_r) < bdq_pkg::CNT_W'(bdq_pkg::DEPTH))
    else $error("front pointer out of range");

  // A store access never writes and reads at once.
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_cmd.we && mem_cmd.re))
    else $error("store written and read in the same cycle");

  // An accepted push raises the count by one.
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (req_fire && resp.status == bdq_pkg::ST_PUSHED) |=>
      count_r == $past(count_r) + bdq_pkg::CNT_W'(1))
    else $error("push did not raise the count");

  // A refused request leaves pointer and count alone.
  a_refuse_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (req_fire && (resp.status == bdq_pkg::ST_FULL ||
                  resp.status == bdq_pkg::ST_EMPTY)) |=>
      ($stable(count_r) && $stable(front_r)))
    else $error("refused request changed the deque");

endmodule

FILE: rtl/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Bounded double-ended queue of signed 32-bit values held in a circular
// single-port store, with a configurable capacity.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                                 Handshake
//   -------   -----------------------------------   -------------------------
//   request   in_action, in_push_value              start high, busy low
//   result    out_status, out_result_value          out_valid, one cycle
//   config    cfg_wdata (capacity)                  cfg_we, no wait
//
// The result of each request appears in the next cycle, once the store read
// of a pop has returned; a new request can be taken every cycle while busy is
// low, set by the single store port used once per request.
// Reset is synchronous; busy stays high until the clock edge after release.
// The store is not cleared: only entries already pushed are ever read.
// The receiver takes every result on its strobe and cannot stall the block.
// ----------------------------------------------------------------------------
module bounded_deque (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_action,
  input  logic signed [bdq_pkg::DATA_W-1:0]  in_push_value,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic signed [bdq_pkg::DATA_W-1:0]  out_result_value,
  input  logic                               cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]          cfg_wdata
);

  logic                        busy_r;
  logic [bdq_pkg::CAP_W-1:0]   capacity_r;
  logic                        req_fire;
  bdq_pkg::mem_cmd_t           mem_cmd;
  bdq_pkg::resp_t              resp;
  bdq_pkg::resp_t              resp_r;
  logic [bdq_pkg::DATA_W-1:0]  rdata;

  assign req_fire = start && !busy_r;
  assign busy     = busy_r;

  // Busy only while coming out of reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= bdq_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  bdq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_fire   (req_fire),
    .action     (in_action),
    .push_value (in_push_value),
    .capacity   (capacity_r),
    .mem_cmd    (mem_cmd),
    .resp       (resp)
  );

  bdq_ram #(
    .DATA_W (bdq_pkg::DATA_W),
    .DEPTH  (bdq_pkg::DEPTH),
    .ADDR_W (bdq_pkg::ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_cmd.we),
    .re    (mem_cmd.re),
    .addr  (mem_cmd.addr),
    .wdata (mem_cmd.wdata),
    .rdata (rdata)
  );

  // Result stage, aligned with the store read data. Only the strobe is reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      resp_r.valid <= 1'b0;
    end else begin
      resp_r.valid <= resp.valid;
    end
    resp_r.status   <= resp.status;
    resp_r.from_mem <= resp.from_mem;
    resp_r.value    <= resp.value;
  end

  // Popped values come straight from the store read port.
  assign out_valid        = resp_r.valid;
  assign out_status       = resp_r.status;
  assign out_result_value = resp_r.from_mem ? $signed(rdata) : $signed(resp_r.value);

  // Every accepted request yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    req_fire |=> out_valid)
    else $error("request produced no result");

  // No result appears without a request in the cycle before.
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(req_fire))
    else $error("result without request");

  // A refused request reports a zero value.
  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == bdq_pkg::ST_FULL ||
                   out_status == bdq_pkg::ST_EMPTY)) |-> out_result_value == '0)
    else $error("refused request with nonzero value");

endmodule

FILE: bench/deque_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deque_checker
// Watches the request, result and capacity ports of the bounded deque. It
// keeps its own copy of the deque contents, works out the status and value
// of every accepted request, and compares each result strobe with the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
module deque_checker (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  input  logic                                       busy,
  input  logic [1:0]                                 in_action,
  input  logic signed [bdq_pkg::DATA_W-1:0]          in_push_value,
  input  logic                                       out_valid,
  input  logic [1:0]                                 out_status,
  input  logic signed [bdq_pkg::DATA_W-1:0]          out_result_value,
  input  logic                                       cfg_we,
  input  logic [bdq_pkg::CAP_W-1:0]                  cfg_wdata,
  output int                                         fail_count,
  output int                                         outstanding,
  output int                                         checked_count,
  output int                                         full_count,
  output int                                         empty_count
);

  typedef struct packed {
    logic [1:0]                        status;
    logic signed [bdq_pkg::DATA_W-1:0] value;
  } deque_result_t;

  localparam int PEND_DEPTH = 16;

  // Shadow copy of the deque: circular store, front index and fill level.
  logic signed [bdq_pkg::DATA_W-1:0] shadow_store [bdq_pkg::DEPTH];
  int                                front_idx;
  int                                held;
  logic [bdq_pkg::CAP_W-1:0]         capacity;

  // Predictions waiting for their result, oldest at pend_rd.
  deque_result_t                     pend_fifo [PEND_DEPTH];
  int                                pend_rd;
  int                                pend_wr;
  int                                pend_cnt;
  deque_result_t                     predicted;
  deque_result_t                     observed;

  // Apply one request to the shadow deque and return what the block should
  // report for it.
  task automatic apply_request(input logic [1:0] act,
                               input logic signed [bdq_pkg::DATA_W-1:0] val,
                               output deque_result_t res);
    int limit;
    int slot;
    limit = (int'(capacity) < bdq_pkg::DEPTH) ? int'(capacity) : bdq_pkg::DEPTH;
    res.value = '0;
    if (act == bdq_pkg::ACT_PUSH_HEAD || act == bdq_pkg::ACT_PUSH_TAIL) begin
      if (held >= limit) begin
        res.status = bdq_pkg::ST_FULL;
      end else begin
        if (act == bdq_pkg::ACT_PUSH_HEAD) begin
          front_idx = (front_idx + bdq_pkg::DEPTH - 1) % bdq_pkg::DEPTH;
          slot = front_idx;
        end else begin
          slot = (front_idx + held) % bdq_pkg::DEPTH;
        end
        shadow_store[slot] = val;
        held++;
        res.status = bdq_pkg::ST_PUSHED;
        res.value = val;
      end
    end else begin
      if (held == 0) begin
        res.status = bdq_pkg::ST_EMPTY;
      end else begin
        if (act == bdq_pkg::ACT_POP_HEAD) begin
          slot = front_idx;
          front_idx = (front_idx + 1) % bdq_pkg::DEPTH;
        end else begin
          slot = (front_idx + held - 1) % bdq_pkg::DEPTH;
        end
        res.value = shadow_store[slot];
        held--;
        res.status = bdq_pkg::ST_POPPED;
      end
    end
  endtask

  // Predict on each accepted request, then check any result strobe. The
  // prediction is stored first so the check holds whatever the latency.
  // A capacity write takes effect for requests after its edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      front_idx = 0;
      held = 0;
      capacity = bdq_pkg::CAP_RESET;
      pend_rd = 0;
      pend_wr = 0;
      pend_cnt = 0;
      fail_count = 0;
      checked_count = 0;
      full_count = 0;
      empty_count = 0;
    end else begin
      if (start && !busy) begin
        apply_request(in_action, in_push_value, predicted);
        pend_fifo[pend_wr] = predicted;
        pend_wr = (pend_wr + 1) % PEND_DEPTH;
        pend_cnt++;
      end
      if (cfg_we) begin
        capacity = cfg_wdata;
      end
      if (out_valid) begin
        observed.status = out_status;
        observed.value = out_result_value;
        if (pend_cnt == 0) begin
          if (fail_count < 10) begin
            $display("[%0t] unexpected result: status %0d value %0d", $realtime,
                     observed.status, observed.value);
          end
          fail_count++;
        end else begin
          predicted = pend_fifo[pend_rd];
          pend_rd = (pend_rd + 1) % PEND_DEPTH;
          pend_cnt--;
          checked_count++;
          if (predicted.status == bdq_pkg::ST_FULL) full_count++;
          if (predicted.status == bdq_pkg::ST_EMPTY) empty_count++;
          if (observed.status !== predicted.status
              || observed.value !== predicted.value) begin
            if (fail_count < 10) begin
              $display("[%0t] result mismatch: status exp %0d got %0d, value exp %0d got %0d",
                       $realtime, predicted.status, observed.status,
                       predicted.value, observed.value);
            end
            fail_count++;
          end
        end
      end
    end
    outstanding = pend_cnt;
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the bounded deque with directed and random requests under a range
// of capacity settings, with random request gaps, and gives the verdict
// from the failure and outstanding counts of the checker.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 9;
  localparam int PHASE_LEN   = 55;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic [1:0]                        in_action = bdq_pkg::ACT_POP_HEAD;
  logic signed [bdq_pkg::DATA_W-1:0] in_push_value = '0;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic signed [bdq_pkg::DATA_W-1:0] out_result_value;
  logic                              cfg_we = 1'b0;
  logic [bdq_pkg::CAP_W-1:0]         cfg_wdata = '0;

  int fail_count;
  int outstanding;
  int checked_count;
  int full_count;
  int empty_count;
  int cycle_count = 0;
  bit gaps_on = 1'b1;

  bounded_deque i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  deque_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_result_value(out_result_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .checked_count   (checked_count),
    .full_count      (full_count),
    .empty_count     (empty_count)
  );

  always #5 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Present one request at a falling edge and hold it until it is taken.
  task automatic issue(input logic [1:0] act,
                       input logic signed [bdq_pkg::DATA_W-1:0] val);
    start <= 1'b1;
    in_action <= act;
    in_push_value <= val;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Leave the request line low for the given number of cycles.
  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Random short gap between requests.
  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 3));
  endtask

  // Stop sending until every predicted result has come back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Capacity is only changed with the deque idle.
  task automatic set_capacity(input logic [bdq_pkg::CAP_W-1:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // One random request; push_pct biases between growing and shrinking.
  task automatic random_request(input int push_pct);
    logic [1:0]                        act;
    logic signed [bdq_pkg::DATA_W-1:0] val;
    if ($urandom_range(0, 99) < push_pct) begin
      act = ($urandom_range(0, 1) == 0) ? bdq_pkg::ACT_PUSH_HEAD : bdq_pkg::ACT_PUSH_TAIL;
    end else begin
      act = ($urandom_range(0, 1) == 0) ? bdq_pkg::ACT_POP_HEAD : bdq_pkg::ACT_POP_TAIL;
    end
    case ($urandom_range(0, 7))
      0:       val = 32'h7fff_ffff;
      1:       val = 32'h8000_0000;
      2:       val = '0;
      3:       val = '1;
      default: val = $urandom;
    endcase
    issue(act, val);
    maybe_gap();
  endtask

  // Stimulus: directed corner cases, then random phases over several
  // capacities; the pointers wrap around the store end from the first
  // push at the front.
  initial begin
    int cap_plan [PHASES];
    int phase_len;
    int push_pct;
    cap_plan = '{3, 1, 16, 0, 5, 2047, 1024, 7, 64};

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Empty deque at reset capacity, extreme values at both ends.
    issue(bdq_pkg::ACT_POP_HEAD, '0);
    issue(bdq_pkg::ACT_POP_TAIL, 32'h1234_5678);
    issue(bdq_pkg::ACT_PUSH_HEAD, 32'h7fff_ffff);
    issue(bdq_pkg::ACT_PUSH_TAIL, 32'h8000_0000);
    issue(bdq_pkg::ACT_PUSH_HEAD, '0);
    issue(bdq_pkg::ACT_PUSH_TAIL, '1);
    issue(bdq_pkg::ACT_POP_TAIL, '0);
    issue(bdq_pkg::ACT_POP_HEAD, '0);
    issue(bdq_pkg::ACT_POP_TAIL, '0);
    issue(bdq_pkg::ACT_POP_HEAD, '0);
    issue(bdq_pkg::ACT_POP_HEAD, '0);

    // Zero capacity refuses every push.
    set_capacity(bdq_pkg::CAP_W'(0));
    issue(bdq_pkg::ACT_PUSH_HEAD, 32'h5555_5555);
    issue(bdq_pkg::ACT_PUSH_TAIL, 32'haaaa_aaaa);
    issue(bdq_pkg::ACT_POP_TAIL, '0);

    // Fill to a capacity of two, then lower it below the fill level.
    set_capacity(bdq_pkg::CAP_W'(2));
    issue(bdq_pkg::ACT_PUSH_TAIL, 32'd1);
    issue(bdq_pkg::ACT_PUSH_HEAD, 32'd2);
    issue(bdq_pkg::ACT_PUSH_TAIL, 32'd3);
    set_capacity(bdq_pkg::CAP_W'(1));
    issue(bdq_pkg::ACT_PUSH_HEAD, 32'd4);
    issue(bdq_pkg::ACT_POP_TAIL, '0);
    issue(bdq_pkg::ACT_PUSH_TAIL, 32'd6);
    issue(bdq_pkg::ACT_POP_HEAD, '0);
    issue(bdq_pkg::ACT_PUSH_HEAD, -32'sd5);

    // Random phases; the contents carry over from one capacity to the next.
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) cap_plan[phase] = $urandom_range(8, 64);
      set_capacity(bdq_pkg::CAP_W'(cap_plan[phase]));
      gaps_on = (phase < PHASES - 2) && ($urandom_range(0, 3) != 0);
      phase_len = PHASE_LEN;
      push_pct = $urandom_range(35, 70);
      if (cap_plan[phase] == 2047) begin
        push_pct = 97;
      end else if (cap_plan[phase] == 1024) begin
        push_pct = 4;
      end
      for (int k = 0; k < phase_len; k++) begin
        if (k == phase_len / 2 && $urandom_range(0, 1) == 1) drain();
        random_request(push_pct);
      end
    end

    drain();
    repeat (8) @(negedge clk);
    $display("Summary: %0d requests checked over %0d capacity settings.",
             checked_count, PHASES + 4);
    $display("Summary: %0d pushes refused full, %0d pops refused empty.",
             full_count, empty_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bdq_pkg.sv
rtl/bdq_ram.sv
rtl/bdq_ctrl.sv
rtl/bounded_deque.sv
bench/deque_checker.sv
bench/testbench.sv
